// ----- hdl/atilt_pkg.sv -----
package atilt_pkg;

  // Operation codes carried in the func field
  localparam logic [1:0] FUNC_MEAS = 2'd0;
  localparam logic [1:0] FUNC_CAL  = 2'd1;
  localparam logic [1:0] FUNC_ZERO = 2'd2;
  localparam logic [1:0] FUNC_LOAD = 2'd3;

  // Reset value of the 1 g reference register
  localparam logic [14:0] Y_REF_RESET = 15'd16384;

  // Square root: one result bit per iteration, 24 result bits
  localparam int ISQRT_STEPS = 24;
  // CORDIC vector width: |v| * gain stays below 2^25
  localparam int CORD_W = 27;
  // Arctangent table length and the counter that walks it
  localparam int TAB_LEN = 24;
  localparam int CNT_W   = 5;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam logic [29:0] ATAN_TAB [TAB_LEN] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
    30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
    30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
    30'd234684,    30'd117342,    30'd58671,     30'd29335,
    30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115
  };

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_z;
  } in_t;

  typedef struct packed {
    logic [15:0]        tilt_deg_q8;
    logic               angle_valid;
    logic signed [15:0] corrected_x;
    logic signed [15:0] corrected_y;
    logic signed [15:0] corrected_z;
    logic signed [15:0] current_offset_x;
    logic signed [15:0] current_offset_y;
    logic signed [15:0] current_offset_z;
  } out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             cap;
    logic             corr;
    logic             sq;
    logic             rinit;
    logic             rstep;
    logic             cinit;
    logic             cstep;
    logic             fin;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic meas;
    logic nz;
  } sts_t;

endpackage

// ----- hdl/accel_tilt_angle_with_offset_cal.sv -----
// Channel   Ports                                 Direction
// input     in_valid, in_ready, in_data           in  (func and x, y, z sample)
// result    out_valid, out_ready, out_data        out (tilt, corrected, offsets)
// config    cfg_valid, cfg_ready, cfg_data        in  (1 g reference, 15 bits)
//
// A measure transaction runs the 24 one-bit square-root iterations and then the
// min(CORDIC_STEPS, 24) rotations of the shared shift-add unit before the next
// acceptance; a zero vector skips both, and calibrate, zero and load go from the
// correction to the final write. Reset (rst_n low, synchronous) clears the offsets
// and loads the 1 g reference with 16384. A stalled result waits in the output
// register while the next transaction is taken; only its final write stalls.
module accel_tilt_angle_with_offset_cal #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  atilt_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output atilt_pkg::out_t  out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [14:0]      cfg_data
);

  atilt_pkg::cmd_t cmd;
  atilt_pkg::sts_t sts;

  atilt_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  atilt_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- hdl/atilt_ctrl.sv -----
module atilt_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  atilt_pkg::sts_t  sts,
  output atilt_pkg::cmd_t  cmd
);

  localparam int NSTEPS = (CORDIC_STEPS < atilt_pkg::TAB_LEN) ? CORDIC_STEPS
                                                              : atilt_pkg::TAB_LEN;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CORR  = 3'd1;
  localparam logic [2:0] ST_SQ    = 3'd2;
  localparam logic [2:0] ST_RINIT = 3'd3;
  localparam logic [2:0] ST_ROOT  = 3'd4;
  localparam logic [2:0] ST_CINIT = 3'd5;
  localparam logic [2:0] ST_CSTEP = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic [atilt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // Sequence one transaction through the datapath
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.cnt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_CORR;
        end
      end
      ST_CORR: begin
        cmd.corr  = 1'b1;
        state_nxt = sts.meas ? ST_SQ : ST_FIN;
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = sts.nz ? ST_RINIT : ST_FIN;
      end
      ST_RINIT: begin
        cmd.rinit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.rstep = 1'b1;
        if (cnt_r == atilt_pkg::CNT_W'(atilt_pkg::ISQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_CINIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CINIT: begin
        cmd.cinit = 1'b1;
        state_nxt = ST_CSTEP;
      end
      ST_CSTEP: begin
        cmd.cstep = 1'b1;
        if (cnt_r == atilt_pkg::CNT_W'(NSTEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Set the output valid on a new result, drop it once taken
  always_comb begin
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/atilt_dp.sv -----
module atilt_dp #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  atilt_pkg::in_t   in_data,
  output atilt_pkg::out_t  out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [14:0]      cfg_data,
  input  atilt_pkg::cmd_t  cmd,
  output atilt_pkg::sts_t  sts
);

  localparam int CW  = atilt_pkg::CORD_W;
  // Angle: sign, 9 integer bits, 8 + ANGLE_FRAC_BITS fraction bits
  localparam int AW  = ANGLE_FRAC_BITS + 18;
  localparam int TSH = 16 - ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] ANG90  = AW'(90 << (8 + ANGLE_FRAC_BITS));
  localparam logic signed [AW-1:0] ANG180 = AW'(180 << (8 + ANGLE_FRAC_BITS));
  localparam logic [30:0] TAB_HALF = 31'(1 << (TSH - 1));
  localparam logic [AW-1:0] OUT_HALF = AW'(1 << (ANGLE_FRAC_BITS - 1));

  atilt_pkg::in_t     in_r;
  logic [14:0]        y_ref_r;
  logic signed [15:0] off_x_r, off_y_r, off_z_r;
  logic signed [15:0] cx_r, cy_r, cz_r;
  logic signed [15:0] cx_nxt, cy_nxt, cz_nxt;
  logic [30:0]        sqx_r, sqz_r;
  logic signed [31:0] px, pz;
  logic [47:0]        rad_r;
  logic [24:0]        rem_r;
  logic [23:0]        root_r;
  logic [26:0]        rem_sh, trial;
  logic               ge;
  logic signed [CW-1:0] a_r, b_r, y256, root_ext, da, db;
  logic signed [AW-1:0] ang_r, step, ang_cl;
  logic [30:0]        tab_rnd, tab_sh;
  logic [AW-1:0]      ang_rnd;
  logic [15:0]        tilt;
  atilt_pkg::out_t    out_r;

  assign cfg_ready = 1'b1;

  // Capture the input transaction and the configuration register
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_ref_r <= atilt_pkg::Y_REF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      y_ref_r <= cfg_data;
    end
  end

  // Corrected sample per operation
  always_comb begin
    cx_nxt = '0;
    cy_nxt = '0;
    cz_nxt = '0;
    case (in_r.func)
      atilt_pkg::FUNC_MEAS: begin
        cx_nxt = in_r.sample_x - off_x_r;
        cy_nxt = in_r.sample_y - off_y_r;
        cz_nxt = in_r.sample_z - off_z_r;
      end
      atilt_pkg::FUNC_CAL: begin
        cx_nxt = in_r.sample_x;
        cy_nxt = in_r.sample_y - signed'({1'b0, y_ref_r});
        cz_nxt = in_r.sample_z;
      end
      default: begin
        cx_nxt = '0;
        cy_nxt = '0;
        cz_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.corr) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
    end
  end

  // Offset registers: calibrate, zero and load update them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
    end else if (cmd.corr) begin
      case (in_r.func)
        atilt_pkg::FUNC_CAL: begin
          off_x_r <= cx_nxt;
          off_y_r <= cy_nxt;
          off_z_r <= cz_nxt;
        end
        atilt_pkg::FUNC_ZERO: begin
          off_x_r <= '0;
          off_y_r <= '0;
          off_z_r <= '0;
        end
        atilt_pkg::FUNC_LOAD: begin
          off_x_r <= in_r.sample_x;
          off_y_r <= in_r.sample_y;
          off_z_r <= in_r.sample_z;
        end
        default: begin
          off_x_r <= off_x_r;
        end
      endcase
    end
  end

  assign sts.meas = (in_r.func == atilt_pkg::FUNC_MEAS);
  assign sts.nz   = (cx_r != '0) || (cy_r != '0) || (cz_r != '0);

  // Squares of the horizontal components
  assign px = cx_r * cx_r;
  assign pz = cz_r * cz_r;

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      sqx_r <= px[30:0];
      sqz_r <= pz[30:0];
    end
  end

  // Bit-serial square root of (x^2 + z^2) * 2^16, one result bit a cycle
  assign rem_sh = {rem_r, rad_r[47:46]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (cmd.rinit) begin
      rad_r  <= {{1'b0, sqx_r} + {1'b0, sqz_r}, 16'd0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.rstep) begin
      rad_r  <= {rad_r[45:0], 2'b00};
      rem_r  <= ge ? 25'(rem_sh - trial) : rem_sh[24:0];
      root_r <= {root_r[22:0], ge};
    end
  end

  // CORDIC vectoring: one rotation a cycle through a shared shift-add unit
  assign y256     = {{(CW - 24){cy_r[15]}}, cy_r, 8'd0};
  assign root_ext = {{(CW - 24){1'b0}}, root_r};
  assign da       = b_r >>> cmd.cnt;
  assign db       = a_r >>> cmd.cnt;
  assign tab_rnd  = {1'b0, atilt_pkg::ATAN_TAB[cmd.cnt]} + TAB_HALF;
  assign tab_sh   = tab_rnd >> TSH;
  assign step     = signed'(AW'(tab_sh));

  always_ff @(posedge clk) begin
    if (cmd.cinit) begin
      // Turn a downward vector by 90 degrees first
      if (cy_r[15]) begin
        a_r   <= root_ext;
        b_r   <= -y256;
        ang_r <= ANG90;
      end else begin
        a_r   <= y256;
        b_r   <= root_ext;
        ang_r <= '0;
      end
    end else if (cmd.cstep) begin
      if (!b_r[CW-1]) begin
        a_r   <= a_r + da;
        b_r   <= b_r - db;
        ang_r <= ang_r + step;
      end else begin
        a_r   <= a_r - da;
        b_r   <= b_r + db;
        ang_r <= ang_r - step;
      end
    end
  end

  // Clamp to 0..180 degrees and round to 8 fraction bits
  always_comb begin
    if (ang_r[AW-1]) begin
      ang_cl = '0;
    end else if (ang_r > ANG180) begin
      ang_cl = ANG180;
    end else begin
      ang_cl = ang_r;
    end
  end

  assign ang_rnd = unsigned'(ang_cl) + OUT_HALF;
  assign tilt    = 16'(ang_rnd >> ANGLE_FRAC_BITS);

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_r.tilt_deg_q8      <= (sts.meas && sts.nz) ? tilt : 16'd0;
      out_r.angle_valid      <= sts.meas && sts.nz;
      out_r.corrected_x      <= cx_r;
      out_r.corrected_y      <= cy_r;
      out_r.corrected_z      <= cz_r;
      out_r.current_offset_x <= off_x_r;
      out_r.current_offset_y <= off_y_r;
      out_r.current_offset_z <= off_z_r;
    end
  end

  assign out_data = out_r;

endmodule

// ----- verif/tilt_checker.sv -----
module tilt_checker #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  atilt_pkg::in_t  in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  atilt_pkg::out_t out_data,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [14:0]     cfg_data,
  output int              mismatches,
  output int              outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  // atan(2^-i) in degrees with 24 fraction bits
  localparam longint ARCTAN_DEG_Q24 [0:23] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523,  7509720,   3754917,   1877466,   938734,   469367,
    234684,    117342,    58671,     29335,     14668,    7334,
    3667,      1833,      917,       458,       229,      115
  };

  logic signed [15:0] off_x, off_y, off_z;
  logic [14:0]        y_ref;
  atilt_pkg::out_t    expected_readings [$];
  int                 err_count;

  assign mismatches = err_count;

  // Bit-serial integer square root, floor of sqrt(v)
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Tilt from the y axis: CORDIC vectoring of (y, sqrt(x^2+z^2)), Q8.8 degrees
  function automatic logic [15:0] tilt_angle_q8(longint x, longint y, longint z);
    longint unsigned horiz_sq;
    longint          a, b, da, db, ang, lim, step, t;
    int              tsh;
    tsh      = 16 - ANGLE_FRAC_BITS;
    horiz_sq = x * x + z * z;
    a        = y * 256;
    b        = longint'(int_sqrt(horiz_sq << 16));
    ang      = 0;
    lim      = longint'(180) << (8 + ANGLE_FRAC_BITS);
    // Turn vectors in the lower half by 90 degrees first
    if (a < 0) begin
      t   = a;
      a   = b;
      b   = -t;
      ang = longint'(90) << (8 + ANGLE_FRAC_BITS);
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      step = (ARCTAN_DEG_Q24[i] + (longint'(1) << (tsh - 1))) >>> tsh;
      da   = b >>> i;
      db   = a >>> i;
      if (b >= 0) begin
        a   = a + da;
        b   = b - db;
        ang = ang + step;
      end else begin
        a   = a - da;
        b   = b + db;
        ang = ang - step;
      end
    end
    if (ang < 0) ang = 0;
    if (ang > lim) ang = lim;
    ang = (ang + (longint'(1) << (ANGLE_FRAC_BITS - 1))) >>> ANGLE_FRAC_BITS;
    if (ang > 46080) ang = 46080;
    return ang[15:0];
  endfunction

  // Work out the result of one transaction and advance the held offsets
  task automatic predict_reading(input atilt_pkg::in_t s, output atilt_pkg::out_t r);
    r = '0;
    case (s.func)
      atilt_pkg::FUNC_MEAS: begin
        r.corrected_x = s.sample_x - off_x;
        r.corrected_y = s.sample_y - off_y;
        r.corrected_z = s.sample_z - off_z;
        if (r.corrected_x != 0 || r.corrected_y != 0 || r.corrected_z != 0) begin
          r.tilt_deg_q8 = tilt_angle_q8(longint'(r.corrected_x),
                                        longint'(r.corrected_y),
                                        longint'(r.corrected_z));
          r.angle_valid = 1'b1;
        end
      end
      atilt_pkg::FUNC_CAL: begin
        r.corrected_x = s.sample_x;
        r.corrected_y = s.sample_y - $signed({1'b0, y_ref});
        r.corrected_z = s.sample_z;
        off_x = r.corrected_x;
        off_y = r.corrected_y;
        off_z = r.corrected_z;
      end
      atilt_pkg::FUNC_ZERO: begin
        off_x = '0;
        off_y = '0;
        off_z = '0;
      end
      atilt_pkg::FUNC_LOAD: begin
        off_x = s.sample_x;
        off_y = s.sample_y;
        off_z = s.sample_z;
      end
      default: ;
    endcase
    r.current_offset_x = off_x;
    r.current_offset_y = off_y;
    r.current_offset_z = off_z;
  endtask

  task automatic check_field(input string field, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
      err_count++;
    end
  endtask

  initial err_count = 0;

  // Watch the three channels: compare results first, then predict new ones
  always @(posedge clk) begin : watch
    atilt_pkg::out_t want;
    atilt_pkg::out_t got;
    if (!rst_n) begin
      off_x = '0;
      off_y = '0;
      off_z = '0;
      y_ref = atilt_pkg::Y_REF_RESET;
      expected_readings.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, got);
          err_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("tilt_deg_q8", longint'(want.tilt_deg_q8),
                      longint'(got.tilt_deg_q8));
          check_field("angle_valid", longint'(want.angle_valid),
                      longint'(got.angle_valid));
          check_field("corrected_x", longint'(want.corrected_x),
                      longint'(got.corrected_x));
          check_field("corrected_y", longint'(want.corrected_y),
                      longint'(got.corrected_y));
          check_field("corrected_z", longint'(want.corrected_z),
                      longint'(got.corrected_z));
          check_field("current_offset_x", longint'(want.current_offset_x),
                      longint'(got.current_offset_x));
          check_field("current_offset_y", longint'(want.current_offset_y),
                      longint'(got.current_offset_y));
          check_field("current_offset_z", longint'(want.current_offset_z),
                      longint'(got.current_offset_z));
        end
      end
      if (cfg_valid && cfg_ready) y_ref = cfg_data;
      if (in_valid && in_ready) begin
        predict_reading(in_data, want);
        expected_readings.push_back(want);
      end
    end
    outstanding <= expected_readings.size();
  end

endmodule

// ----- verif/accel_tilt_angle_with_offset_cal_tb.sv -----
module accel_tilt_angle_with_offset_cal_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 8;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  atilt_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_ready;
  atilt_pkg::out_t out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [14:0]     cfg_data;
  int              mismatches;
  int              outstanding;
  bit              tx_quiet;
  bit              rx_quiet;

  accel_tilt_angle_with_offset_cal #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  tilt_checker #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold one sample on the input channel until it is taken
  task automatic send_sample(input logic [1:0] f, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic signed [15:0] z);
    int              gap;
    atilt_pkg::in_t  item;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.func     = f;
    item.sample_x = x;
    item.sample_y = y;
    item.sample_z = z;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reference(input logic [14:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Axis value: full range, near zero, typical gravity counts or the corners
  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return $signed(16'($urandom_range(0, 16))) - 16'sd8;
      2:       return $signed(16'($urandom_range(0, 40000))) - 16'sd20000;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  // One random transaction or a short well-formed sequence; returns how many were sent
  task automatic random_sequence(output int sent);
    logic signed [15:0] x, y, z;
    int                 r;
    x = pick_axis();
    y = pick_axis();
    z = pick_axis();
    r = $urandom_range(0, 99);
    sent = 1;
    if (r < 55) begin
      send_sample(atilt_pkg::FUNC_MEAS, x, y, z);
    end else if (r < 65) begin
      // Calibrate then measure: resting sample and a tilted one
      send_sample(atilt_pkg::FUNC_CAL, x, y, z);
      send_sample(atilt_pkg::FUNC_MEAS, x, y, z);
      send_sample(atilt_pkg::FUNC_MEAS, pick_axis(), pick_axis(), pick_axis());
      sent = 3;
    end else if (r < 72) begin
      // Load then measure the same counts, sometimes nudged off the zero vector
      send_sample(atilt_pkg::FUNC_LOAD, x, y, z);
      if ($urandom_range(0, 1) == 0)
        send_sample(atilt_pkg::FUNC_MEAS, x, y, z);
      else
        send_sample(atilt_pkg::FUNC_MEAS, x + 16'($urandom_range(0, 2)), y - 16'sd1, z);
      sent = 2;
    end else if (r < 80) begin
      send_sample(atilt_pkg::FUNC_CAL, x, y, z);
    end else if (r < 88) begin
      send_sample(atilt_pkg::FUNC_ZERO, x, y, z);
    end else begin
      send_sample(atilt_pkg::FUNC_LOAD, x, y, z);
    end
  endtask

  // Result side: random stalls with quiet stretches
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    rx_quiet = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic [14:0] phase_ref [0:5];
    int          count;
    int          sent;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    tx_quiet  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero vector, the axes, the corners, calibrate, load, zero and wrap
    send_sample(atilt_pkg::FUNC_MEAS, 16'sd0, 16'sd0, 16'sd0);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sd0, 16'sd16384, 16'sd0);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sd0, -16'sd16384, 16'sd0);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sd16384, 16'sd0, 16'sd0);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sd0, 16'sd0, -16'sd16384);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sh7fff, 16'sh8000, 16'sd0);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sh8000, 16'sd0, 16'sh7fff);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sd1, 16'sd0, 16'sd0);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sd0, -16'sd1, 16'sd0);
    send_sample(atilt_pkg::FUNC_CAL, 16'sd100, 16'sd16000, -16'sd50);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sd100, 16'sd16000, -16'sd50);
    send_sample(atilt_pkg::FUNC_CAL, 16'sh7fff, 16'sh8000, 16'sh8000);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send_sample(atilt_pkg::FUNC_LOAD, 16'sd5, 16'sd6, 16'sd7);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sd5, 16'sd6, 16'sd7);
    send_sample(atilt_pkg::FUNC_LOAD, 16'sh7fff, 16'sh8000, 16'sd1);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(atilt_pkg::FUNC_ZERO, 16'shffff, 16'shffff, 16'shffff);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sd0, 16'sd0, 16'sd0);
    send_sample(atilt_pkg::FUNC_MEAS, 16'sh0200, 16'sh0000, 16'shfe00);

    // Random phases, each under its own 1 g reference
    phase_ref[0] = 15'd0;
    phase_ref[1] = 15'd32767;
    phase_ref[2] = 15'($urandom_range(0, 32767));
    phase_ref[3] = 15'd1;
    phase_ref[4] = 15'($urandom_range(0, 32767));
    phase_ref[5] = atilt_pkg::Y_REF_RESET;
    for (int p = 0; p < 6; p++) begin
      drain();
      write_reference(phase_ref[p]);
      send_sample(atilt_pkg::FUNC_CAL, 16'sd0, 16'sh8000, 16'sd0);
      count = 1;
      while (count < 100) begin
        random_sequence(sent);
        count += sent;
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/atilt_pkg.sv
hdl/atilt_ctrl.sv
hdl/atilt_dp.sv
hdl/accel_tilt_angle_with_offset_cal.sv
verif/tilt_checker.sv
verif/accel_tilt_angle_with_offset_cal_tb.sv
